>>> hw/rtl/dwnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwnp_pkg
// shared constants for the delta word nibble packer
// ----------------------------------------------------------------------------
package dwnp_pkg;

  localparam int unsigned WordBitsDef = 32;
  localparam int unsigned NibbleW     = 4;
  localparam int unsigned PendW       = 3;
  localparam int unsigned ShortLen    = 6;
  localparam int unsigned DeltaW      = 5;

endpackage

>>> hw/rtl/dwnp_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwnp_encoder
// delta coder with short escape; merges the token with the carried bits
// and holds previous word and carry state
// ----------------------------------------------------------------------------
module dwnp_encoder #(
  parameter int unsigned WORD_BITS = dwnp_pkg::WordBitsDef,
  parameter int unsigned NIB_MAX   = (WORD_BITS + 7) / 4,
  parameter int unsigned BUF_W     = NIB_MAX * 4,
  parameter int unsigned CNT_W     = $clog2(NIB_MAX + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [WORD_BITS-1:0] word_i,
  input  logic                 last_i,
  input  logic                 commit_i,
  output logic [BUF_W-1:0]     buf_o,
  output logic [CNT_W-1:0]     cnt_o
);
  import dwnp_pkg::*;

  localparam int unsigned LenW = $clog2(BUF_W + 1);

  logic [WORD_BITS-1:0] prev_q, prev_d;
  logic [PendW-1:0]     pend_q, pend_d;
  logic [1:0]           pcnt_q, pcnt_d;

  logic [WORD_BITS:0]   diff;
  logic                 is_short;
  logic [BUF_W-1:0]     token_la;
  logic [BUF_W-1:0]     stream;
  logic [LenW-1:0]      n;
  logic [LenW-3:0]      nfull;
  logic [1:0]           rem;
  logic [NibbleW-1:0]   rem_nib;

  always_comb begin
    diff     = {1'b0, word_i} - {1'b0, prev_q};
    is_short = (diff[WORD_BITS:DeltaW-1] == '0) || (diff[WORD_BITS:DeltaW-1] == '1);
    if (is_short) begin
      token_la = {1'b0, diff[DeltaW-1:0], {(BUF_W - ShortLen){1'b0}}};
      n        = LenW'(pcnt_q) + LenW'(ShortLen);
    end else begin
      token_la = {1'b1, word_i, {(BUF_W - 1 - WORD_BITS){1'b0}}};
      n        = LenW'(pcnt_q) + LenW'(WORD_BITS + 1);
    end
    stream = {pend_q, {(BUF_W - PendW){1'b0}}} | (token_la >> pcnt_q);
    nfull  = n[LenW-1:2];
    rem    = n[1:0];
  end

  // nibble that holds the leftover bits, zero padded
  always_comb begin
    rem_nib = '0;
    for (int i = 0; i < NIB_MAX; i++) begin
      if (nfull == (LenW-2)'(i)) begin
        rem_nib = stream[BUF_W-1-4*i -: NibbleW];
      end
    end
  end

  assign buf_o = stream;
  assign cnt_o = CNT_W'(nfull) + CNT_W'(last_i && (rem != 2'd0));

  always_comb begin
    if (last_i) begin
      prev_d = '0;
      pend_d = '0;
      pcnt_d = '0;
    end else begin
      prev_d = word_i;
      pend_d = rem_nib[NibbleW-1 -: PendW];
      pcnt_d = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pend_q <= '0;
      pcnt_q <= '0;
    end else if (commit_i) begin
      prev_q <= prev_d;
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
    end
  end

endmodule

>>> hw/rtl/dwnp_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwnp_serializer
// result register that shifts one nibble out per transfer
// ----------------------------------------------------------------------------
module dwnp_serializer #(
  parameter int unsigned BUF_W = 36,
  parameter int unsigned CNT_W = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [BUF_W-1:0]   buf_i,
  input  logic [CNT_W-1:0]   cnt_i,
  input  logic               last_i,
  output logic               load_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         nibble_o,
  output logic               last_nibble_o
);
  import dwnp_pkg::*;

  logic [BUF_W-1:0] buf_q;
  logic [CNT_W-1:0] cnt_q;
  logic             last_q;
  logic             xfer;

  assign out_valid_o   = (cnt_q != '0);
  assign xfer          = out_valid_o && out_ready_i;
  assign load_ready_o  = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_ready_i);
  assign nibble_o      = buf_q[BUF_W-1 -: NibbleW];
  assign last_nibble_o = last_q && (cnt_q == CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= 1'b0;
    end else if (load_i) begin
      cnt_q  <= cnt_i;
      last_q <= last_i;
    end else if (xfer) begin
      cnt_q  <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= buf_i;
    end else if (xfer) begin
      buf_q <= buf_q << NibbleW;
    end
  end

endmodule

>>> hw/rtl/delta_word_nibble_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_word_nibble_packer
// delta coder with a short escape, packing its codes into 4-bit nibbles
// ----------------------------------------------------------------------------
// A word enters an input register, is coded combinationally and moves into a
// nibble shift register; the next word is taken while those nibbles drain.
// Each word sends out the nibbles it produces, one per transfer: one or
// two for a short delta and (WORD_BITS + 1 + carry) / 4, i.e. 8 or 9 at
// 32 bits, for an escaped word, plus one zero-padded nibble when a last word
// leaves bits over, so at most 9 at 32 bits. The one-nibble-per-transfer
// output port sets the rate; an accepted word passes the input register
// and the nibble shift register before its first nibble leaves.
module delta_word_nibble_packer #(
  parameter int unsigned WORD_BITS = dwnp_pkg::WordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_BITS-1:0] word_i,
  input  logic                 last_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           nibble_o,
  output logic                 last_nibble_o
);
  import dwnp_pkg::*;

  localparam int unsigned NibMax = (WORD_BITS + 7) / 4;
  localparam int unsigned BufW   = NibMax * 4;
  localparam int unsigned CntW   = $clog2(NibMax + 1);

  logic                 iv_q;
  logic [WORD_BITS-1:0] word_q;
  logic                 last_q;
  logic                 load;
  logic                 load_ready;
  logic [BufW-1:0]      enc_buf;
  logic [CntW-1:0]      enc_cnt;

  assign load       = iv_q && load_ready;
  assign in_ready_o = !iv_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_ready_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= word_i;
      last_q <= last_word_i;
    end
  end

  dwnp_encoder #(
    .WORD_BITS (WORD_BITS),
    .NIB_MAX   (NibMax),
    .BUF_W     (BufW),
    .CNT_W     (CntW)
  ) u_encoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (word_q),
    .last_i   (last_q),
    .commit_i (load),
    .buf_o    (enc_buf),
    .cnt_o    (enc_cnt)
  );

  dwnp_serializer #(
    .BUF_W (BufW),
    .CNT_W (CntW)
  ) u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .buf_i         (enc_buf),
    .cnt_i         (enc_cnt),
    .last_i        (last_q),
    .load_ready_o  (load_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .nibble_o      (nibble_o),
    .last_nibble_o (last_nibble_o)
  );

endmodule

>>> hw/rtl/dwnp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwnp_checker
// port-level checks for the delta word nibble packer
// ----------------------------------------------------------------------------
module dwnp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] nibble_o,
  input logic       last_nibble_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(nibble_o)
                                    && $stable(last_nibble_o))
    else $error("result changed while stalled");

  // with no result pending the input side is always open
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // input only stalls behind pending results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |-> out_valid_o)
    else $error("input stalled without pending results");

  // every word transfer is followed by a valid result once the word has passed the input register
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 out_valid_o)
    else $error("no result after word transfer");

endmodule

bind delta_word_nibble_packer dwnp_checker u_dwnp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .nibble_o      (nibble_o),
  .last_nibble_o (last_nibble_o)
);
